### rtl/core/kdear_pkg.sv
// ----------------------------------------------------------------------------
// kdear_pkg: shared definitions for the key debounce and autorepeat block
// Widths, configuration register indexes, reset values and the result type.
// ----------------------------------------------------------------------------
package kdear_pkg;

    localparam int unsigned KeyBits  = 16;
    localparam int unsigned ByteBits = 8;
    localparam int unsigned CfgBits  = 16;
    localparam int unsigned IdxBits  = 2;

    typedef logic [KeyBits-1:0]  key_word_t;
    typedef logic [ByteBits-1:0] key_byte_t;
    typedef logic [CfgBits-1:0]  cfg_word_t;

    // Configuration register indexes.
    typedef enum logic [IdxBits-1:0] {
        CFG_REPEAT_MASK   = 2'd0,
        CFG_REPEAT_DELAY  = 2'd1,
        CFG_REPEAT_PERIOD = 2'd2
    } cfg_index_t;

    localparam cfg_word_t RepeatMaskReset   = 16'd0;
    localparam cfg_word_t RepeatDelayReset  = 16'd20;
    localparam cfg_word_t RepeatPeriodReset = 16'd5;

    // One result transaction; the packed words are formed at the port.
    typedef struct packed {
        key_word_t pressed;
        key_word_t held;
    } result_t;

endpackage : kdear_pkg

### rtl/core/key_debounce_edge_autorepeat.sv
// ----------------------------------------------------------------------------
// key_debounce_edge_autorepeat: key debounce with press edges and autorepeat
// Debounces a 16-bit raw key word per frame and reports presses and repeats.
// ----------------------------------------------------------------------------
// One input transaction per frame tick carries two raw key bytes. The block
// accepts one transaction in every clock cycle while in_stall is low and gives
// exactly one result transaction for each: the whole update of the
// debounce, latch and countdown state is a single stage of bitwise logic and
// one 16-bit decrement that writes into the result or the skid register. A
// two-entry output (result register plus skid register) lets the input keep
// flowing while a result waits; in_stall rises only when both are occupied.
// Configuration writes must be made while no transaction is in flight.
// ----------------------------------------------------------------------------
module key_debounce_edge_autorepeat
(
    input  logic                    clk,
    input  logic                    rst_n,

    // Configuration write port
    input  logic                    cfg_we,
    input  logic [1:0]              cfg_index,
    input  kdear_pkg::cfg_word_t    cfg_data,

    // Input channel: one frame of raw key bytes
    input  logic                    in_valid,
    output logic                    in_stall,
    input  kdear_pkg::key_byte_t    key_byte_high,
    input  kdear_pkg::key_byte_t    key_byte_low,

    // Output channel: one result per frame
    output logic                    out_valid,
    input  logic                    out_stall,
    output kdear_pkg::key_word_t    pressed_mask,
    output kdear_pkg::key_word_t    held_mask,
    output kdear_pkg::key_word_t    first_word,
    output kdear_pkg::key_word_t    second_word
);

    import kdear_pkg::*;

    // Configuration registers.
    cfg_word_t repeat_mask_reg;
    cfg_word_t repeat_delay_reg;
    cfg_word_t repeat_period_reg;

    // Key state.
    key_word_t previous_raw_reg;
    key_word_t level_reg;
    key_word_t press_latch_reg;
    cfg_word_t countdown_reg;

    // Output stage: result register and skid register.
    result_t   result_reg;
    result_t   skid_reg;
    logic      out_valid_reg;
    logic      skid_valid_reg;

    // Next-state logic.
    key_word_t raw;
    key_word_t changed;
    key_word_t level_next;
    key_word_t latch_kept;
    key_word_t press_latch_next;
    cfg_word_t countdown_dec;
    cfg_word_t countdown_next;
    logic      reload;
    logic      expire;
    result_t   result_next;
    logic      in_accept;
    logic      out_take;

    assign in_accept = in_valid && !in_stall;
    assign out_take  = out_valid_reg && !out_stall;

    // Configuration writes; an index outside the register list is ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            repeat_mask_reg   <= RepeatMaskReset;
            repeat_delay_reg  <= RepeatDelayReset;
            repeat_period_reg <= RepeatPeriodReset;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_REPEAT_MASK:   repeat_mask_reg   <= cfg_data;
                CFG_REPEAT_DELAY:  repeat_delay_reg  <= cfg_data;
                CFG_REPEAT_PERIOD: repeat_period_reg <= cfg_data;
                default:           ;
            endcase
        end
    end

    // A bit takes the raw value only if it held steady since the last frame.
    // The countdown restarts from the initial delay whenever a held repeat key
    // bounces or no repeat key is held; otherwise it counts down (wrapping
    // from zero); on reaching zero it restarts from the repeat period and clears
    // the repeat keys' latch so that held ones are reported again on this frame.
    always_comb
    begin
        raw           = {key_byte_high, key_byte_low};
        changed       = previous_raw_reg ^ raw;
        level_next    = (~changed & raw) | (changed & level_reg);
        reload        = ((changed & level_reg & repeat_mask_reg) != '0) ||
                        ((level_next & repeat_mask_reg) == '0);
        countdown_dec = countdown_reg - 16'd1;
        expire        = (countdown_dec == '0);
        latch_kept    = press_latch_reg & level_next;

        if (reload)
        begin
            countdown_next = repeat_delay_reg;
        end
        else if (expire)
        begin
            countdown_next = repeat_period_reg;
            latch_kept     = latch_kept & ~repeat_mask_reg;
        end
        else
        begin
            countdown_next = countdown_dec;
        end

        result_next.pressed = level_next & ~latch_kept;
        result_next.held    = level_next;
        press_latch_next    = latch_kept | result_next.pressed;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            previous_raw_reg <= '0;
            level_reg        <= '0;
            press_latch_reg  <= '0;
            countdown_reg    <= '0;
        end
        else if (in_accept)
        begin
            previous_raw_reg <= raw;
            level_reg        <= level_next;
            press_latch_reg  <= press_latch_next;
            countdown_reg    <= countdown_next;
        end
    end

    // Output stage. A new result goes to the result register if it is free
    // or being drained this cycle, otherwise it parks in the skid register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (out_take)
            begin
                skid_valid_reg <= 1'b0;
            end
        end
        else if (in_accept)
        begin
            if (out_valid_reg && !out_take)
            begin
                skid_valid_reg <= 1'b1;
            end
            out_valid_reg <= 1'b1;
        end
        else if (out_take)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (out_take)
            begin
                result_reg <= skid_reg;
            end
        end
        else if (in_accept)
        begin
            if (out_valid_reg && !out_take)
            begin
                skid_reg <= result_next;
            end
            else
            begin
                result_reg <= result_next;
            end
        end
    end

    assign in_stall     = skid_valid_reg;
    assign out_valid    = out_valid_reg;
    assign pressed_mask = result_reg.pressed;
    assign held_mask    = result_reg.held;
    assign first_word   = {result_reg.held[15:8], result_reg.pressed[15:8]};
    assign second_word  = {result_reg.held[7:0], result_reg.pressed[7:0]};

    // The press latch only ever marks keys that are currently held.
    assert property (@(posedge clk) disable iff (!rst_n)
        (press_latch_reg & ~level_reg) == '0)
        else $error("press latch holds a key that is not held");

    // The skid register is only occupied behind a valid result.
    assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid register full while result register empty");

    // After an accepted transaction, out_valid is always high on the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> out_valid_reg)
        else $error("accepted transaction produced no result");

    // A reported press is always a held key.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> ((result_reg.pressed & ~result_reg.held) == '0))
        else $error("pressed key reported that is not held");

endmodule : key_debounce_edge_autorepeat

### verif/key_debounce_edge_autorepeat_tb.sv
// ----------------------------------------------------------------------------
// key_debounce_edge_autorepeat_tb: self-checking bench for key debounce
// Drives raw key frames through the block and checks every result transaction
// against a cycle-free model of the debounce, press latch and repeat countdown.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module key_debounce_edge_autorepeat_tb;

    import kdear_pkg::*;

    // The port has four index codes but only three registers; writes to the
    // spare code must leave the configuration untouched.
    localparam logic [IdxBits-1:0] CfgSpareIndex = 2'd3;

    // Cycles of quiet after the last result before registers are rewritten.
    // The block has a single stage, so a handful is ample.
    localparam int unsigned SettleCycles = 4;
    // Length of the deliberate receiver hold-off used to fill the output skid.
    localparam int unsigned HoldOffCycles = 40;
    // Cycles without any accepted transaction before the run is abandoned.
    localparam int unsigned WatchdogLimit = 1000;
    // Mismatch lines printed before further ones are only counted.
    localparam int unsigned PrintLimit = 30;

    typedef enum int {
        IDLE_NONE,
        IDLE_SEND,
        IDLE_RECV,
        IDLE_BOTH
    } idle_mode_t;

    // One expected result transaction, with the packed words spelt out.
    typedef struct {
        key_word_t pressed;
        key_word_t held;
        key_word_t first;
        key_word_t second;
    } frame_result_t;

    // ------------------------------------------------------------------------
    // Clock, reset and block inputs, all known from time zero.
    // ------------------------------------------------------------------------
    logic                clk           = 1'b0;
    logic                rst_n         = 1'b0;
    logic                cfg_we        = 1'b0;
    logic [IdxBits-1:0]  cfg_index     = '0;
    cfg_word_t           cfg_data      = '0;
    logic                in_valid      = 1'b0;
    key_byte_t           key_byte_high = '0;
    key_byte_t           key_byte_low  = '0;
    logic                out_stall     = 1'b0;

    logic                in_stall;
    logic                out_valid;
    key_word_t           pressed_mask;
    key_word_t           held_mask;
    key_word_t           first_word;
    key_word_t           second_word;

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    key_debounce_edge_autorepeat u_top
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .key_byte_high (key_byte_high),
        .key_byte_low  (key_byte_low),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .pressed_mask  (pressed_mask),
        .held_mask     (held_mask),
        .first_word    (first_word),
        .second_word   (second_word)
    );

    // ------------------------------------------------------------------------
    // Model state. The configuration mirrors the registers after each write;
    // the rest mirrors the block's frame-to-frame state.
    // ------------------------------------------------------------------------
    key_word_t repeat_keys   = RepeatMaskReset;
    key_word_t first_delay   = RepeatDelayReset;
    key_word_t repeat_gap    = RepeatPeriodReset;

    key_word_t last_raw      = '0;
    key_word_t key_level     = '0;
    key_word_t reported_keys = '0;
    key_word_t frames_left   = '0;

    frame_result_t expected_frames[$];

    int unsigned send_idle_pct    = 0;
    int unsigned recv_idle_pct    = 0;
    int unsigned holdoff_requests = 0;
    int unsigned holdoff_served   = 0;
    int unsigned holdoff_left     = 0;

    int unsigned mismatches       = 0;
    int unsigned frames_sent      = 0;
    int unsigned results_checked  = 0;
    int unsigned autorepeats      = 0;
    int unsigned settings_applied = 0;
    int unsigned backpressure     = 0;
    int unsigned quiet_cycles     = 0;

    // Advances the model by one raw frame and returns the result it implies.
    // A raw bit only moves the debounced level once it has been seen twice in
    // a row. The shared countdown restarts whenever a held repeat key bounces
    // or no repeat key is held, and otherwise ticks down, re-arming every
    // repeat key's press latch when it hits zero. Starting the tick from zero
    // wraps round to the full 16-bit range.
    function automatic frame_result_t debounce_frame(input key_word_t raw);
        key_word_t     changed;
        key_word_t     old_level;
        key_word_t     pressed;
        frame_result_t result;
        changed       = last_raw ^ raw;
        old_level     = key_level;
        key_level     = (~changed & raw) | (changed & old_level);
        last_raw      = raw;
        reported_keys = reported_keys & key_level;

        if ((changed & old_level & repeat_keys) != '0 || (key_level & repeat_keys) == '0)
        begin
            frames_left = first_delay;
        end
        else
        begin
            frames_left = frames_left - 1'b1;
            if (frames_left == '0)
            begin
                frames_left   = repeat_gap;
                reported_keys = reported_keys & ~repeat_keys;
                autorepeats++;
            end
        end

        pressed        = key_level & ~reported_keys;
        reported_keys  = reported_keys | pressed;
        result.pressed = pressed;
        result.held    = key_level;
        result.first   = {key_level[15:8], pressed[15:8]};
        result.second  = {key_level[7:0], pressed[7:0]};
        return result;
    endfunction

    task automatic report(input string msg);
        mismatches++;
        if (mismatches <= PrintLimit)
        begin
            $display("[%0t] MISMATCH: %s", $realtime, msg);
        end
    endtask

    task automatic check_field(input string name, input key_word_t got, input key_word_t want);
        if (got !== want)
        begin
            report($sformatf("%s is %h, expected %h", name, got, want));
        end
    endtask

    // ------------------------------------------------------------------------
    // Handshake helpers. Inputs change just after a rising edge; handshake
    // signals are sampled at the falling edge, when everything has settled,
    // which decides what the following rising edge will accept.
    // ------------------------------------------------------------------------
    task automatic set_idle(input idle_mode_t mode);
        send_idle_pct = (mode == IDLE_SEND) ? 48 : (mode == IDLE_BOTH) ? 11 : 0;
        recv_idle_pct = (mode == IDLE_RECV) ? 48 : (mode == IDLE_BOTH) ? 11 : 0;
    endtask

    // Offers one frame and returns once it has been taken. The payload is
    // only touched between transactions, so it never moves while stalled.
    task automatic send_frame(input key_word_t raw);
        bit taken;
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid      <= 1'b1;
        key_byte_high <= raw[15:8];
        key_byte_low  <= raw[7:0];
        do
        begin
            @(negedge clk);
            taken = !in_stall;
            @(posedge clk);
        end
        while (!taken);
        expected_frames.push_back(debounce_frame(raw));
        frames_sent++;
    endtask

    // Stops offering and waits for every outstanding result. The loop waits on
    // a clock edge before it checks, so the valid is never lowered and raised in one step.
    task automatic drain();
        in_valid <= 1'b0;
        do
        begin
            @(posedge clk);
        end
        while (expected_frames.size() != 0);
    endtask

    task automatic settle();
        drain();
        repeat (SettleCycles) @(posedge clk);
    endtask

    // Drives one register write; the caller lowers the write enable.
    task automatic write_reg(input logic [IdxBits-1:0] idx, input cfg_word_t data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        case (idx)
            CFG_REPEAT_MASK:   repeat_keys = data;
            CFG_REPEAT_DELAY:  first_delay = data;
            CFG_REPEAT_PERIOD: repeat_gap  = data;
            default:           ;
        endcase
    endtask

    // Rewrites all three registers with the block idle. A random write to the
    // spare index follows, which must not disturb what was just written.
    task automatic configure(input cfg_word_t mask, input cfg_word_t delay,
                             input cfg_word_t period);
        settle();
        write_reg(CFG_REPEAT_MASK, mask);
        write_reg(CFG_REPEAT_DELAY, delay);
        write_reg(CFG_REPEAT_PERIOD, period);
        write_reg(CfgSpareIndex, cfg_word_t'($urandom));
        cfg_we <= 1'b0;
        settings_applied++;
    endtask

    // ------------------------------------------------------------------------
    // Receiver: random stalls per the idle mode, plus on request one long
    // hold-off counted here, which fills both output registers.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (holdoff_requests != holdoff_served)
        begin
            holdoff_served <= holdoff_served + 1;
            holdoff_left   <= HoldOffCycles - 1;
            out_stall      <= 1'b1;
        end
        else if (holdoff_left != 0)
        begin
            holdoff_left <= holdoff_left - 1;
            out_stall    <= 1'b1;
        end
        else
        begin
            out_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    // Result checker: every accepted result transaction is matched against
    // the oldest frame still waiting for one.
    always @(negedge clk)
    begin : check_results
        frame_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_frames.size() == 0)
            begin
                report("result transaction with no frame outstanding");
            end
            else
            begin
                want = expected_frames.pop_front();
                check_field("pressed_mask", pressed_mask, want.pressed);
                check_field("held_mask", held_mask, want.held);
                check_field("first_word", first_word, want.first);
                check_field("second_word", second_word, want.second);
                results_checked++;
            end
        end
    end

    // Watchdog: a run in which nothing moves for too long has hung.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_stall)
            begin
                backpressure++;
            end
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
            begin
                quiet_cycles = 0;
            end
            else
            begin
                quiet_cycles++;
            end
            if (quiet_cycles >= WatchdogLimit)
            begin
                $display("[%0t] TIMEOUT: no transaction for %0d cycles, %0d results outstanding",
                         $realtime, quiet_cycles, expected_frames.size());
                $display("Mismatches found");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Reset configuration, no autorepeat: all-zero and all-one frames, each
    // byte alone, alternating patterns and a one-frame bounce that the
    // debounce must swallow.
    task automatic test_field_extremes();
        key_word_t frames[] = '{16'h0000, 16'hFFFF, 16'hFFFF, 16'hFF00, 16'hFF00,
                                16'h00FF, 16'h00FF, 16'h0000, 16'h0000, 16'h55AA,
                                16'hAA55, 16'hAA55, 16'h8001, 16'h8001};
        set_idle(IDLE_NONE);
        foreach (frames[i])
        begin
            send_frame(frames[i]);
        end
    endtask

    // Mostly steady key patterns with random content, so that the debounce
    // settles and the countdown gets to run out; the rest are single-key
    // presses and releases, one-frame bounces and wholesale changes.
    task automatic test_random_frames(input int unsigned count);
        key_word_t steady;
        key_word_t frame;
        int unsigned pick;
        steady = key_word_t'($urandom);
        repeat (count)
        begin
            pick = $urandom_range(99);
            if (pick < 6)
            begin
                steady = steady ^ (key_word_t'(1) << $urandom_range(KeyBits - 1));
            end
            else if (pick < 8)
            begin
                steady = key_word_t'($urandom);
            end
            frame = (pick >= 8 && pick < 13) ? steady ^ key_word_t'($urandom) : steady;
            send_frame(frame);
        end
    endtask

    // Only the mask is written, so the first repeat and the repeat spacing
    // come from the reset values of the delay and period registers.
    task automatic test_reset_timing();
        settle();
        write_reg(CFG_REPEAT_MASK, 16'hFFFF);
        cfg_we <= 1'b0;
        set_idle(IDLE_NONE);
        test_random_frames(250);
    endtask

    // Walks the countdown through its special cases: expiry with a period of
    // one, a reload when a held repeat key bounces, a reload when no repeat
    // key is held, and a zero delay and period so that the count wraps.
    task automatic test_countdown_cases();
        key_word_t frames[] = '{16'h0F0F, 16'h0F0F, 16'h0F0F, 16'h0F0F, 16'h0E0F,
                                16'h0F0F, 16'h0F0F, 16'h0F0F, 16'hF0F0, 16'hF0F0,
                                16'hFFFF};
        configure(16'h0F0F, 16'd2, 16'd1);
        set_idle(IDLE_NONE);
        foreach (frames[i])
        begin
            send_frame(frames[i]);
        end
        configure(16'h0F0F, 16'd0, 16'd0);
        repeat (4) send_frame(16'h0F0F);
    endtask

    // The receiver holds off long enough for the block to fill and stall its
    // input while frames keep coming; then the sender waits for every result
    // before carrying on under random receiver stalls.
    task automatic test_output_holdoff();
        configure(16'hFFFF, 16'd4, 16'd2);
        set_idle(IDLE_NONE);
        holdoff_requests++;
        test_random_frames(40);
        drain();
        set_idle(IDLE_RECV);
        test_random_frames(40);
    endtask

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        test_field_extremes();
        test_reset_timing();
        test_countdown_cases();

        configure(cfg_word_t'($urandom), 16'd1, 16'd1);
        set_idle(IDLE_SEND);
        test_random_frames(220);

        configure(cfg_word_t'($urandom), cfg_word_t'($urandom_range(2, 8)),
                  cfg_word_t'($urandom_range(1, 4)));
        set_idle(IDLE_RECV);
        test_random_frames(220);

        configure(cfg_word_t'($urandom), 16'hFFFF, 16'hFFFF);
        set_idle(IDLE_BOTH);
        test_random_frames(150);

        configure(cfg_word_t'($urandom), 16'd3, 16'd2);
        set_idle(IDLE_BOTH);
        test_random_frames(220);

        test_output_holdoff();

        configure(16'hFFFF, 16'd0, 16'd0);
        set_idle(IDLE_NONE);
        test_random_frames(100);

        settle();
        if (expected_frames.size() != 0)
        begin
            report($sformatf("%0d results never arrived", expected_frames.size()));
        end

        $display("Sent %0d key frames under %0d register settings; checked %0d results.",
                 frames_sent, settings_applied + 1, results_checked);
        $display("Saw %0d autorepeat expiries and %0d cycles of input back-pressure.",
                 autorepeats, backpressure);
        if (mismatches == 0)
        begin
            $display("No mismatches found");
        end
        else
        begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule : key_debounce_edge_autorepeat_tb

### key_debounce_edge_autorepeat.f
rtl/core/kdear_pkg.sv
rtl/core/key_debounce_edge_autorepeat.sv
verif/key_debounce_edge_autorepeat_tb.sv
